[rtl/core/pclbl_pkg.sv]
// shared package for the per-client leaky bucket limiter
// holds widths, register indexes, event codes, fsm states and the ctrl/datapath structs
// no dependencies

package pclbl_pkg;

  // table geometry
  localparam int CLIENT_SLOTS = 32;
  localparam int COUNT_BITS   = 20;
  localparam int SCAN_W       = $clog2(CLIENT_SLOTS);

  // field widths fixed by the item format
  localparam int SLOT_W   = 5;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;
  localparam int OCOUNT_W = 20;

  // configuration registers
  localparam int RATE_W     = 16;
  localparam int BURST_W    = 20;
  localparam int INTERVAL_W = 8;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int DRAIN_W    = RATE_W + TIME_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

  localparam logic [RATE_W-1:0]     RATE_RESET     = 16'd200;
  localparam logic [BURST_W-1:0]    BURST_RESET    = 20'd400;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    EV_RELEASED   = 2'd0,
    EV_LIMITED    = 2'd1,
    EV_RECORDED   = 2'd2,
    EV_REGISTERED = 2'd3
  } event_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_REQ
  } state_t;

  typedef struct packed {
    logic              load_item;
    logic              load_drain;
    logic              scan_step;
    logic              req_step;
    logic [SCAN_W-1:0] scan_idx;
  } pclbl_cmd_t;

  typedef struct packed {
    logic decay_due;
    logic out_free;
  } pclbl_sts_t;

endpackage

[rtl/core/pclbl_in_if.sv]
// request channel: client slot and timestamp with valid/ready
// depends on pclbl_pkg for field widths

interface pclbl_in_if;
  logic                          valid;
  logic                          ready;
  logic [pclbl_pkg::SLOT_W-1:0]  client_slot;
  logic [pclbl_pkg::TIME_W-1:0]  now_seconds;

  modport source (output valid, output client_slot, output now_seconds, input ready);
  modport sink   (input valid, input client_slot, input now_seconds, output ready);
endinterface

[rtl/core/pclbl_out_if.sv]
// event channel: one item per release and one per request, valid/ready
// depends on pclbl_pkg for field widths

interface pclbl_out_if;
  logic                           valid;
  logic                           ready;
  logic [pclbl_pkg::SLOT_W-1:0]   event_slot;
  logic [pclbl_pkg::KIND_W-1:0]   event_kind;
  logic [pclbl_pkg::OCOUNT_W-1:0] slot_count;
  logic                           is_last;

  modport source (output valid, output event_slot, output event_kind, output slot_count,
                  output is_last, input ready);
  modport sink   (input valid, input event_slot, input event_kind, input slot_count,
                  input is_last, output ready);
endinterface

[rtl/core/pclbl_ctrl.sv]
// sequencer for the limiter: accept, decay check, slot walk, request update
// depends on pclbl_pkg for states and the command/status structs

module pclbl_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pclbl_pkg::pclbl_sts_t   sts,
  output pclbl_pkg::pclbl_cmd_t   cmd
);
  import pclbl_pkg::*;

  state_t            state_r, state_nxt;
  logic [SCAN_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.scan_idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.decay_due) begin
          cmd.load_drain = 1'b1;
          idx_nxt        = '0;
          state_nxt      = ST_SCAN;
        end else begin
          state_nxt = ST_REQ;
        end
      end
      ST_SCAN: begin
        // one slot per cycle, held while the event register cannot take a new event
        if (sts.out_free) begin
          cmd.scan_step = 1'b1;
          if (idx_r == SCAN_W'(CLIENT_SLOTS - 1)) begin
            state_nxt = ST_REQ;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_REQ: begin
        if (sts.out_free) begin
          cmd.req_step = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_step && cmd.req_step))
    else $error("scan and request step in the same cycle");

  a_walk_ends_in_req: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && idx_r == SCAN_W'(CLIENT_SLOTS - 1)) |=> state_r == ST_REQ)
    else $error("slot walk did not hand over to the request step");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_item |-> state_r == ST_IDLE && in_valid)
    else $error("item loaded outside idle");

endmodule

[rtl/core/pclbl_dp.sv]
// datapath: config registers, slot table, drain multiply, event output register
// depends on pclbl_pkg; driven by pclbl_ctrl through the command struct

module pclbl_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pclbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pclbl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [pclbl_pkg::SLOT_W-1:0]      in_slot,
  input  logic [pclbl_pkg::TIME_W-1:0]      in_now,
  input  pclbl_pkg::pclbl_cmd_t             cmd,
  output pclbl_pkg::pclbl_sts_t             sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [pclbl_pkg::SLOT_W-1:0]      out_slot,
  output logic [pclbl_pkg::KIND_W-1:0]      out_kind,
  output logic [pclbl_pkg::OCOUNT_W-1:0]    out_count,
  output logic                              out_last
);
  import pclbl_pkg::*;

  logic [RATE_W-1:0]     rate_r;
  logic [BURST_W-1:0]    burst_r;
  logic [INTERVAL_W-1:0] interval_r;

  logic [SLOT_W-1:0]     slot_r;
  logic [TIME_W-1:0]     now_r;
  logic [TIME_W-1:0]     last_time_r;
  logic [DRAIN_W-1:0]    drain_r;

  logic [CLIENT_SLOTS-1:0] known_r;
  logic [CLIENT_SLOTS-1:0] limited_r;
  logic [COUNT_BITS-1:0]   count_r [CLIENT_SLOTS];

  logic                  out_valid_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [KIND_W-1:0]     out_kind_r;
  logic [OCOUNT_W-1:0]   out_count_r;
  logic                  out_last_r;

  logic [TIME_W-1:0]     elapsed;
  logic                  out_free;
  logic [SCAN_W-1:0]     rd_idx;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  rd_known;
  logic                  rd_limited;
  logic                  drain_small;
  logic [COUNT_BITS-1:0] decayed;
  logic                  scan_active;
  logic                  scan_release;
  logic                  slot_in_range;
  logic [COUNT_BITS-1:0] bumped;
  logic                  goes_limited;
  logic                  emit;

  assign elapsed       = now_r - last_time_r;
  assign out_free      = !out_valid_r || out_ready;
  assign sts.out_free  = out_free;
  assign sts.decay_due = (now_r >= last_time_r) &&
                         (elapsed >= TIME_W'(interval_r));

  // single read port into the slot table
  assign rd_idx     = cmd.scan_step ? cmd.scan_idx : SCAN_W'(slot_r);
  assign rd_count   = count_r[rd_idx];
  assign rd_known   = known_r[rd_idx];
  assign rd_limited = limited_r[rd_idx];

  // saturating subtract of the drain, floored at zero
  assign drain_small  = (drain_r[DRAIN_W-1:COUNT_BITS] == '0);
  assign decayed      = (drain_small && rd_count > drain_r[COUNT_BITS-1:0]) ?
                        rd_count - drain_r[COUNT_BITS-1:0] : '0;
  assign scan_active  = rd_known && (rd_count != '0);
  assign scan_release = scan_active && rd_limited &&
                        (decayed < COUNT_BITS'(rate_r));

  assign slot_in_range = (int'(slot_r) < CLIENT_SLOTS);
  assign bumped        = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;
  assign goes_limited  = !rd_limited && (bumped > COUNT_BITS'(burst_r));

  assign emit = cmd.req_step || (cmd.scan_step && scan_release);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= RATE_RESET;
      burst_r    <= BURST_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE:     rate_r     <= cfg_data[RATE_W-1:0];
        CFG_BURST:    burst_r    <= cfg_data[BURST_W-1:0];
        CFG_INTERVAL: interval_r <= cfg_data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      slot_r <= in_slot;
      now_r  <= in_now;
    end
    if (cmd.load_drain) begin
      drain_r <= DRAIN_W'({{TIME_W{1'b0}}, rate_r} * {{RATE_W{1'b0}}, elapsed});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
    end else if (cmd.load_drain) begin
      last_time_r <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
    end else if (cmd.req_step && slot_in_range && !rd_known) begin
      known_r[rd_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && scan_active) begin
      count_r[rd_idx] <= decayed;
      if (scan_release) begin
        limited_r[rd_idx] <= 1'b0;
      end
    end else if (cmd.req_step && slot_in_range) begin
      if (rd_known) begin
        count_r[rd_idx] <= bumped;
        if (goes_limited) begin
          limited_r[rd_idx] <= 1'b1;
        end
      end else begin
        count_r[rd_idx]   <= '0;
        limited_r[rd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (cmd.scan_step) begin
        out_slot_r  <= SLOT_W'(cmd.scan_idx);
        out_kind_r  <= EV_RELEASED;
        out_count_r <= OCOUNT_W'(decayed);
        out_last_r  <= 1'b0;
      end else begin
        out_slot_r <= slot_r;
        out_last_r <= 1'b1;
        if (!slot_in_range) begin
          out_kind_r  <= EV_RECORDED;
          out_count_r <= '0;
        end else if (rd_known) begin
          out_kind_r  <= goes_limited ? EV_LIMITED : EV_RECORDED;
          out_count_r <= OCOUNT_W'(bumped);
        end else begin
          out_kind_r  <= EV_REGISTERED;
          out_count_r <= '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_kind  = out_kind_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("event posted over an unread event");

  a_req_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.req_step |=> out_valid_r && out_last_r)
    else $error("request step did not post the final event");

  a_decay_time: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_drain |=> last_time_r == $past(now_r))
    else $error("decay time not advanced to the request time");

endmodule

[rtl/core/per_client_leaky_bucket_limiter.sv]
// top level of the per-client leaky bucket limiter
// depends on pclbl_pkg, pclbl_in_if, pclbl_out_if, pclbl_ctrl and pclbl_dp

// One request item in, one or more event items out. Each request is handled
// alone: after it is taken the block checks in its check state whether the
// decay interval has passed; if so it forms the drain (rate times elapsed
// seconds) and walks all 32 slots, one slot per cycle while the event channel
// can take an event, through the single table read port, posting a released
// event for each limited slot that falls below the rate. It then applies the
// request and posts its event with is_last set. The last event may still sit
// in the output register while the next request is taken. The user must
// write configuration through cfg_we/cfg_index/cfg_data only while no request
// is in flight; the block itself does not enforce this. Slot state is only
// defined once a slot has been registered by a first request; the known-slot
// map clears at reset.

module per_client_leaky_bucket_limiter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pclbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pclbl_pkg::CFG_DATA_W-1:0]  cfg_data,
  pclbl_in_if.sink                          in_ch,
  pclbl_out_if.source                       out_ch
);
  import pclbl_pkg::*;

  pclbl_cmd_t cmd;
  pclbl_sts_t sts;

  // sequencer: owns the state and the slot walk counter
  pclbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, config registers, drain multiply and event register
  pclbl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_slot   (in_ch.client_slot),
    .in_now    (in_ch.now_seconds),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_slot  (out_ch.event_slot),
    .out_kind  (out_ch.event_kind),
    .out_count (out_ch.slot_count),
    .out_last  (out_ch.is_last)
  );

endmodule

[bench/pclbl_event_checker.sv]
`timescale 1ns / 100ps
// event checker for the per-client leaky bucket limiter: mirrors slot table and config,
// forecasts the events of each accepted request and compares them with the event channel
// depends on pclbl_pkg, pclbl_in_if and pclbl_out_if

module pclbl_event_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pclbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pclbl_pkg::CFG_DATA_W-1:0] cfg_data,
  pclbl_in_if                              in_mon,
  pclbl_out_if                             out_mon,
  output int                               mismatches,
  output int                               events_due
);
  import pclbl_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    event_kind_t         kind;
    logic [OCOUNT_W-1:0] count;
    logic                last;
  } limiter_event_t;

  limiter_event_t          due_events[$];
  logic [CLIENT_SLOTS-1:0] slot_known;
  logic [CLIENT_SLOTS-1:0] slot_limited;
  logic [COUNT_BITS-1:0]   slot_counts [CLIENT_SLOTS];
  logic [TIME_W-1:0]       decayed_at;
  logic [RATE_W-1:0]       rate;
  logic [BURST_W-1:0]      burst;
  logic [INTERVAL_W-1:0]   interval;

  // decay pass first (releases in slot order), then the request itself
  task automatic forecast_events(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0]  elapsed;
    logic [DRAIN_W-1:0] drain;
    event_kind_t        kind;
    elapsed = stamp - decayed_at;
    if (stamp >= decayed_at && elapsed >= TIME_W'(interval)) begin
      // full-width product, so a long gap with a nonzero rate floors every count at zero
      drain = DRAIN_W'(rate) * DRAIN_W'(elapsed);
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        if (slot_known[i] && slot_counts[i] != '0) begin
          if (DRAIN_W'(slot_counts[i]) > drain) begin
            slot_counts[i] = slot_counts[i] - COUNT_BITS'(drain);
          end else begin
            slot_counts[i] = '0;
          end
          if (slot_limited[i] && slot_counts[i] < COUNT_BITS'(rate)) begin
            slot_limited[i] = 1'b0;
            due_events.push_back(limiter_event_t'{SLOT_W'(i), EV_RELEASED, slot_counts[i],
                                                  1'b0});
          end
        end
      end
      decayed_at = stamp;
    end
    if (slot_known[slot]) begin
      kind = EV_RECORDED;
      if (slot_counts[slot] != COUNT_MAX) begin
        slot_counts[slot] = slot_counts[slot] + 1'b1;
      end
      if (!slot_limited[slot] && slot_counts[slot] > COUNT_BITS'(burst)) begin
        slot_limited[slot] = 1'b1;
        kind = EV_LIMITED;
      end
      due_events.push_back(limiter_event_t'{slot, kind, slot_counts[slot], 1'b1});
    end else begin
      slot_known[slot]   = 1'b1;
      slot_counts[slot]  = '0;
      slot_limited[slot] = 1'b0;
      due_events.push_back(limiter_event_t'{slot, EV_REGISTERED, {OCOUNT_W{1'b0}}, 1'b1});
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    limiter_event_t want;
    if (!rst_n) begin
      slot_known   = '0;
      slot_limited = '0;
      foreach (slot_counts[i]) slot_counts[i] = '0;
      decayed_at = '0;
      rate       = RATE_RESET;
      burst      = BURST_RESET;
      interval   = INTERVAL_RESET;
      due_events.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATE:     rate     = cfg_data[RATE_W-1:0];
          CFG_BURST:    burst    = cfg_data[BURST_W-1:0];
          CFG_INTERVAL: interval = cfg_data[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (due_events.size() == 0) begin
          $error("unexpected event: slot %0d kind %0d count %0d", out_mon.event_slot,
                 out_mon.event_kind, out_mon.slot_count);
          mismatches++;
        end else begin
          want = due_events.pop_front();
          check_field("event_slot", 32'(want.slot), 32'(out_mon.event_slot));
          check_field("event_kind", 32'(want.kind), 32'(out_mon.event_kind));
          check_field("slot_count", 32'(want.count), 32'(out_mon.slot_count));
          check_field("is_last", 32'(want.last), 32'(out_mon.is_last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        forecast_events(in_mon.client_slot, in_mon.now_seconds);
      end
    end
    events_due = due_events.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// top of the bench for the per-client leaky bucket limiter: clock, reset, request
// stimulus, event channel back-pressure, watchdog and verdict
// depends on pclbl_pkg, pclbl_in_if, pclbl_out_if, the limiter and pclbl_event_checker

module testbench;
  import pclbl_pkg::*;

  // longest stretch with no item moving on either channel before we give up;
  // worst correct case is the long receiver hold-off plus a full decay walk
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int MAX_GAP         = 40;
  localparam int DRAIN_CYCLES    = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pclbl_in_if  in_ch ();
  pclbl_out_if out_ch ();

  int mismatches;
  int events_due;

  // sender idling is local to the stimulus process, receiver stalling is not
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  logic [TIME_W-1:0] stamp;
  logic [SLOT_W-1:0] hot_slots [3];

  per_client_leaky_bucket_limiter i_dut (
    .clk,
    .rst_n,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pclbl_event_checker i_checker (
    .clk,
    .rst_n,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .events_due (events_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // event channel ready: random stalls, or a long hold-off on request so the
  // block backs up into its input while the sender keeps offering
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served  <= hold_asked;
      hold_left    <= HOLD_OFF_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog: any accept on either channel counts as progress
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request; valid stays high across back-to-back items and this task
  // only drops it when an idle gap goes in front of the next one
  task automatic offer_request(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] when);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.client_slot <= slot;
    in_ch.now_seconds <= when;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until every forecast event has come out; the
  // checker count is read at the falling edge so it is settled
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (events_due != 0);
    @(posedge clk);
  endtask

  // all three registers in consecutive cycles, only while the block is idle
  task automatic write_regs(input int rate, input int burst, input int spacing);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RATE;
    cfg_data  <= CFG_DATA_W'(rate);
    @(posedge clk);
    cfg_index <= CFG_BURST;
    cfg_data  <= CFG_DATA_W'(burst);
    @(posedge clk);
    cfg_index <= CFG_INTERVAL;
    cfg_data  <= CFG_DATA_W'(spacing);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly a few hot clients so counts climb past the burst limit
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 99) < 75) return hot_slots[$urandom_range(0, 2)];
    return SLOT_W'($urandom_range(0, CLIENT_SLOTS - 1));
  endfunction

  // time mostly holds or creeps forward around the decay interval; a few
  // requests step back behind the previous stamp; wide mode makes long jumps
  // and clamps at the top of the 32-bit range
  function automatic logic [TIME_W-1:0] pick_stamp(input int spacing, input bit wide);
    int unsigned     roll;
    logic [TIME_W:0] ahead;
    roll  = $urandom_range(0, 99);
    ahead = {1'b0, stamp};
    if (roll >= 95 && stamp > 0) begin
      return stamp - TIME_W'($urandom_range(1, (stamp < 8) ? stamp : 8));
    end
    if (roll >= 88) begin
      if (wide) ahead = ahead + $urandom_range(0, 32'h00FF_FFFF);
      else      ahead = ahead + $urandom_range(spacing, 3 * spacing + 3);
    end else if (roll >= 60) begin
      ahead = ahead + $urandom_range(1, (spacing > 0) ? spacing : 1);
    end
    stamp = ahead[TIME_W] ? '1 : ahead[TIME_W-1:0];
    return stamp;
  endfunction

  // one random phase: new config, idle shape, optional long receiver hold-off
  // or a sender pause until drained, both at mid-phase
  task automatic run_phase(input int rate, input int burst, input int spacing,
                           input int idle_pct, input int stall_pct, input int count,
                           input bit wide, input bit hold, input bit pause);
    settle_block();
    write_regs(rate, burst, spacing);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    foreach (hot_slots[k]) hot_slots[k] = SLOT_W'($urandom_range(0, CLIENT_SLOTS - 1));
    if (wide) stamp = 32'h8000_0000 + $urandom_range(0, 32'h7F00_0000);
    for (int n = 0; n < count; n++) begin
      if (hold && n == count / 2) hold_asked <= hold_asked + 1;
      if (pause && n == count / 2) settle_block();
      offer_request(pick_slot(), pick_stamp(spacing, wide));
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_RATE;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.client_slot = '0;
    in_ch.now_seconds = '0;
    stamp             = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rate 3, burst 2, interval 2, no idling on either side
    write_regs(3, 2, 2);
    offer_request(5'd0, 32'd0);    // first request registers
    offer_request(5'd31, 32'd0);
    repeat (4) offer_request(5'd0, 32'd0);  // counts 1..4, limited at 3
    offer_request(5'd31, 32'd0);
    offer_request(5'd5, 32'd1);    // under the interval, no decay
    offer_request(5'd5, 32'd1);
    offer_request(5'd0, 32'd3);    // decay floors counts, slot 0 released
    offer_request(5'd0, 32'd1);    // time behind the last decay
    offer_request(5'd0, 32'd2);    // limited again

    // zero rate drains and releases nothing, zero interval decays every time
    settle_block();
    write_regs(0, 2, 0);
    offer_request(5'd0, 32'd3);
    offer_request(5'd31, 32'd3);

    // zero elapsed time with a nonzero rate still releases below-rate slots
    settle_block();
    write_regs(5, 2, 0);
    offer_request(5'd31, 32'd3);
    stamp = 32'd3;

    run_phase(2, 4, 1, 0, 0, 25, 1'b0, 1'b1, 1'b0);
    run_phase(1, 1, 3, 68, 0, 25, 1'b0, 1'b0, 1'b1);
    run_phase(2, 5, 2, 0, 68, 25, 1'b0, 1'b0, 1'b0);
    // top of every register range
    run_phase(65535, 1048575, 255, 33, 33, 20, 1'b0, 1'b0, 1'b0);
    // bottom of the legal ranges
    run_phase(1, 1, 1, 33, 33, 25, 1'b0, 1'b0, 1'b0);
    // jump into the upper half of time: huge drain product floors everything
    run_phase(65535, 3, 1, 33, 33, 20, 1'b1, 1'b0, 1'b0);
    offer_request(hot_slots[0], '1);
    offer_request(hot_slots[0], '1);

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && events_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/pclbl_pkg.sv
rtl/core/pclbl_in_if.sv
rtl/core/pclbl_out_if.sv
rtl/core/pclbl_ctrl.sv
rtl/core/pclbl_dp.sv
rtl/core/per_client_leaky_bucket_limiter.sv
bench/pclbl_event_checker.sv
bench/testbench.sv
